FILE: hw/rtl/kmal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmal_pkg
// Shared types and constants of the knob moving-average level core.
// ----------------------------------------------------------------------------
package kmal_pkg;

  // full-scale converter code that the mean level is referred to
  localparam int FULL_SCALE = 1023;

  // result is an unsigned Q0.16 fraction
  localparam int          LEVEL_W   = 16;
  localparam int          DIV_CNT_W = $clog2(LEVEL_W);
  localparam logic [15:0] LEVEL_MAX = 16'hFFFF;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } kmal_state_t;

endpackage

FILE: hw/rtl/kmal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/knob_moving_average_level_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_moving_average_level_core
// Moving average of a volume-knob reading, reported as a Q0.16 level.
// ----------------------------------------------------------------------------
// Each accepted sample replaces the oldest entry of a ring of WINDOW samples
// held in a RAM, the running sum is corrected, and the level
// floor(sum * 65536 / (count * 1023)) is returned, saturated at 65535; count
// is the number of samples so far until the window is full, then WINDOW. A
// sample passes from acceptance to a loaded result through the sum update,
// the scaled denominator, a saturation compare, 16 steps of a one-bit-per-cycle
// restoring divider (skipped when the level saturates), and the output load.
// The ring read is issued at acceptance. The input is ready again in the cycle
// after the load, so a new sample is taken only once the last one is through.
// The input is not ready until the result has moved into the output register,
// which then waits for the sink without holding up the next sample. Ring
// entries not yet written since reset read as zero through the fill state, so
// no clearing pass follows reset.
// ----------------------------------------------------------------------------
module knob_moving_average_level_core
  import kmal_pkg::*;
#(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,  // knob_sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,  // level_fraction
  output logic                                 out_tuser   // window_full
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_MAX = WINDOW * ((1 << SAMPLE_BITS) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int DEN_W   = CNT_W + 10;
  localparam int CMP_W   = ((SUM_W > DEN_W) ? SUM_W : DEN_W) + 1;

  kmal_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   filled_r, filled_nxt;
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic [DEN_W-1:0]       rem_r, rem_nxt;
  logic [LEVEL_W-1:0]     quo_r, quo_nxt;
  logic                   sat_r, sat_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [LEVEL_W-1:0]     out_level_r, out_level_nxt;
  logic                   out_full_r, out_full_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_acc;
  logic                   out_load;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [CNT_W-1:0]       count;
  logic [CMP_W-1:0]       sum_ext;
  logic [CMP_W-1:0]       den_ext;
  logic [DEN_W:0]         rem_dbl;
  logic [DEN_W:0]         den_dbl;

  kmal_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (in_acc),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  assign in_acc   = in_tvalid && in_tready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = (sum_ext >= den_ext) ? ST_DONE : ST_DIV;
      ST_DIV:    if (div_cnt_r == DIV_CNT_W'(LEVEL_W - 1)) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_UPDATE: ram_we    = 1'b1;
      ST_SCALE, ST_CHECK, ST_DIV, ST_DONE: begin
        in_tready = 1'b0;
      end
      default:   in_tready = 1'b0;
    endcase
  end

  // unwritten entries only exist before the first wrap, and they read as zero
  assign old_sample = filled_r ? ram_rdata : '0;
  assign count      = filled_r ? CNT_W'(WINDOW) : CNT_W'(slot_r);
  assign sum_ext    = {{(CMP_W - SUM_W){1'b0}}, sum_r};
  assign den_ext    = {{(CMP_W - DEN_W){1'b0}}, den_r};
  assign rem_dbl    = {rem_r, 1'b0};
  assign den_dbl    = {1'b0, den_r};

  // datapath
  always_comb begin
    sample_nxt    = sample_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    filled_nxt    = filled_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    div_cnt_nxt   = div_cnt_r;
    out_level_nxt = out_level_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_acc) begin
      sample_nxt = in_tdata[SAMPLE_BITS-1:0];
    end

    case (state_r)
      ST_UPDATE: begin
        sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        if (slot_r == SLOT_W'(WINDOW - 1)) begin
          slot_nxt   = '0;
          filled_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_SCALE: begin
        den_nxt = DEN_W'(count) * DEN_W'(FULL_SCALE);
      end
      ST_CHECK: begin
        // quotient reaches 65536 exactly when sum >= denominator
        sat_nxt     = (sum_ext >= den_ext);
        rem_nxt     = sum_ext[DEN_W-1:0];
        div_cnt_nxt = '0;
      end
      ST_DIV: begin
        if (rem_dbl >= den_dbl) begin
          rem_nxt = DEN_W'(rem_dbl - den_dbl);
          quo_nxt = {quo_r[LEVEL_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl[DEN_W-1:0];
          quo_nxt = {quo_r[LEVEL_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_level_nxt = sat_r ? LEVEL_MAX : quo_r;
      out_full_nxt  = filled_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    sat_r       <= sat_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_level_r <= out_level_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_level_r;
  assign out_tuser  = out_full_r;

  // divider remainder stays below the denominator
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below denominator");

  // an accepted sample goes straight to the sum update
  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_UPDATE))
    else $error("accepted sample did not start an update");

  // window-full flag never clears after it is set
  a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |=> filled_r)
    else $error("window-full flag cleared");

  // write slot stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < WINDOW)
    else $error("write slot outside the ring");

  // running sum never exceeds the window of full samples
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sum_r) <= SUM_MAX)
    else $error("running sum out of range");

endmodule
